// ===== hw/rtl/multicast_duplicate_filter_macros.svh =====
// Assertion macros for the multicast duplicate filter checker.
// Expects signals named clk and arst_n in the scope where they are used.
`ifndef MULTICAST_DUPLICATE_FILTER_MACROS_SVH
`define MULTICAST_DUPLICATE_FILTER_MACROS_SVH

// Checked at every rising edge outside reset.
`define MDF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("multicast filter: property failed");

// Checked at every rising edge, reset included.
`define MDF_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("multicast filter: reset property failed");

`endif

// ===== hw/rtl/mdf_pkg.sv =====
// Shared types and codes for the multicast duplicate filter.
// No dependencies; used by mdf_cell, the top level and the testbench.
package mdf_pkg;

	localparam int unsigned ID_W   = 16;
	localparam int unsigned SEQ_W  = 8;
	localparam int unsigned LIFE_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCAL_SOURCE = 3'd0,
		CFG_SUBNET_A     = 3'd1,
		CFG_SUBNET_B     = 3'd2,
		CFG_SUBNET_COUNT = 3'd3,
		CFG_LIFETIME     = 3'd4
	} cfg_idx_t;

	// Lookup token that walks down the row of cells.
	typedef struct packed {
		logic valid;
		logic have;  // a candidate entry has been found
		logic hit;   // a live matching entry ended the scan
		logic drop;  // sequence check of the matching entry failed
	} token_t;

	// Broadcast commands from the top level to every cell.
	typedef struct packed {
		logic age;
		logic wr_en;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/mdf_cell.sv =====
// One cache entry of the multicast duplicate filter with its stage of the lookup chain.
// Depends on mdf_pkg.
module mdf_cell import mdf_pkg::*; #(
	parameter int unsigned IDX_W    = 4,
	parameter int unsigned CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [LIFE_W-1:0] lifetime,
	input  logic [ID_W-1:0]   subnet_id,
	input  logic [ID_W-1:0]   source_id,
	input  logic [SEQ_W-1:0]  seq_num,
	input  token_t            tok_in,
	input  logic [IDX_W-1:0]  pick_in,
	output token_t            tok_out,
	output logic [IDX_W-1:0]  pick_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [LIFE_W-1:0] life_q;
	logic [ID_W-1:0]   source_q;
	logic [ID_W-1:0]   subnet_q;
	logic [SEQ_W-1:0]  seq_q;
	token_t            tok_q;
	logic [IDX_W-1:0]  pick_q;
	token_t            tok_nxt;
	logic [IDX_W-1:0]  pick_nxt;
	logic [SEQ_W-1:0]  seq_diff;
	logic              wr_here;

	assign wr_here  = ctl.wr_en && (wr_idx == MY_IDX);
	assign seq_diff = seq_num - seq_q;

	// A free entry takes the candidate over from any earlier one; a live match
	// takes it and freezes the token for the remaining cells.
	always_comb begin
		tok_nxt  = tok_in;
		pick_nxt = pick_in;
		if (tok_in.valid && !tok_in.hit) begin
			if (life_q == '0) begin
				tok_nxt.have = 1'b1;
				pick_nxt     = MY_IDX;
			end else if (source_q == source_id && subnet_q == subnet_id) begin
				tok_nxt.have = 1'b1;
				tok_nxt.hit  = 1'b1;
				tok_nxt.drop = (seq_diff == '0) || seq_diff[SEQ_W-1];
				pick_nxt     = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= '0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr_here) begin
				life_q <= lifetime;
			end else if (ctl.age && life_q != '0) begin
				life_q <= life_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pick_q <= pick_nxt;
		if (wr_here) begin
			source_q <= source_id;
			subnet_q <= subnet_id;
			seq_q    <= seq_num;
		end
	end

	assign tok_out  = tok_q;
	assign pick_out = pick_q;

endmodule

// ===== hw/rtl/multicast_duplicate_filter.sv =====
// Top level of the multicast duplicate filter: configuration registers, own-frame
// check and the row of mdf_cell entries. Depends on mdf_pkg and mdf_cell.
//
// A request is taken when start is high and busy is low; each request gives one
// result, shown for a single cycle with done high, and the receiver cannot hold it
// off. An aging tick, and a header from this node's own source on a local subnet,
// answer in the next cycle and a new request may follow in every cycle. Any other
// header walks a lookup token through the CACHE_ENTRIES cells, one cell a cycle:
// the token leaves the launch register, passes the register of each cell in turn
// and then sets the done register. Busy rises at the edge that takes the header and
// falls at the edge that raises done, which also rewrites the chosen entry. Configuration
// writes are always ready and should only be issued while the filter is idle.
module multicast_duplicate_filter import mdf_pkg::*; #(
	parameter int unsigned CACHE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [ID_W-1:0]      subnet_id,
	input  logic [ID_W-1:0]      source_id,
	input  logic [SEQ_W-1:0]     seq_num,
	output logic                 done,
	output logic                 drop,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data
);

	localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	logic [ID_W-1:0]   local_source_q;
	logic [ID_W-1:0]   subnet_a_q;
	logic [ID_W-1:0]   subnet_b_q;
	logic [1:0]        subnet_count_q;
	logic [LIFE_W-1:0] lifetime_q;

	logic [ID_W-1:0]   subnet_id_q;
	logic [ID_W-1:0]   source_id_q;
	logic [SEQ_W-1:0]  seq_num_q;
	logic              busy_q;
	logic              launch_q;
	logic              done_q;
	logic              drop_q;

	logic              accept;
	logic              own_frame;
	logic              local_subnet;
	cell_ctl_t         ctl;
	token_t            tok   [CACHE_ENTRIES+1];
	logic [IDX_W-1:0]  pick  [CACHE_ENTRIES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_source_q <= '0;
			subnet_a_q     <= '0;
			subnet_b_q     <= '0;
			subnet_count_q <= 2'd1;
			lifetime_q     <= LIFE_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOCAL_SOURCE: local_source_q <= cfg_data;
				CFG_SUBNET_A:     subnet_a_q     <= cfg_data;
				CFG_SUBNET_B:     subnet_b_q     <= cfg_data;
				CFG_SUBNET_COUNT: subnet_count_q <= cfg_data[1:0];
				CFG_LIFETIME:     lifetime_q     <= cfg_data[LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = start && !busy_q;

	// A count of three behaves as two.
	assign local_subnet = (subnet_count_q != 2'd0 && subnet_id == subnet_a_q) ||
	                      (subnet_count_q[1] && subnet_id == subnet_b_q);
	assign own_frame    = (source_id == local_source_q) && local_subnet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept && !req_type && !own_frame;
			done_q   <= (accept && (req_type || own_frame)) || tok[CACHE_ENTRIES].valid;
			if (accept && !req_type && !own_frame) begin
				busy_q <= 1'b1;
			end else if (tok[CACHE_ENTRIES].valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			subnet_id_q <= subnet_id;
			source_id_q <= source_id;
			seq_num_q   <= seq_num;
		end
		if (tok[CACHE_ENTRIES].valid) begin
			drop_q <= !tok[CACHE_ENTRIES].have || tok[CACHE_ENTRIES].drop;
		end else begin
			drop_q <= !req_type && own_frame;
		end
	end

	assign ctl.age   = accept && req_type;
	assign ctl.wr_en = tok[CACHE_ENTRIES].valid && tok[CACHE_ENTRIES].have;

	assign tok[0]  = '{valid: launch_q, have: 1'b0, hit: 1'b0, drop: 1'b0};
	assign pick[0] = '0;

	for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
		mdf_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr_idx    (pick[CACHE_ENTRIES]),
			.lifetime  (lifetime_q),
			.subnet_id (subnet_id_q),
			.source_id (source_id_q),
			.seq_num   (seq_num_q),
			.tok_in    (tok[i]),
			.pick_in   (pick[i]),
			.tok_out   (tok[i+1]),
			.pick_out  (pick[i+1])
		);
	end

	assign busy = busy_q;
	assign done = done_q;
	assign drop = drop_q;

endmodule

// ===== hw/rtl/mdf_checker.sv =====
// Port-level checker for the multicast duplicate filter and its bind to the top level.
// Depends on multicast_duplicate_filter_macros.svh.
`include "multicast_duplicate_filter_macros.svh"

module mdf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic done,
	input logic drop
);

	// A tick request is answered in the next cycle and never drops anything.
	`MDF_ASSERT(a_tick_answer, start && !busy && req_type |=> done && !drop)
	// No result leaves while a lookup is still walking the cells.
	`MDF_ASSERT(a_no_done_busy, busy |-> !done)
	// The end of a lookup always delivers its result.
	`MDF_ASSERT(a_lookup_done, $fell(busy) |-> done)
	// With reset low at consecutive edges, the filter is idle with no result pending.
	`MDF_ASSERT_ALWAYS(a_reset_idle, !arst_n ##1 !arst_n |-> !busy && !done)

endmodule

bind multicast_duplicate_filter mdf_checker u_mdf_checker (.*);

// ===== verif/multicast_duplicate_filter_test.sv =====
// Self-checking testbench for multicast_duplicate_filter: a small cache model predicts
// the drop flag of every request, covering own frames, duplicates, a full cache and aging.
// Depends on mdf_pkg and the multicast_duplicate_filter RTL only.
module multicast_duplicate_filter_test import mdf_pkg::*;;
	localparam int unsigned CACHE_ENTRIES = 16;
	localparam int unsigned PAIRS = 20;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 322;

	class dup_filter_scoreboard;
		logic [ID_W-1:0]   own_source;
		logic [ID_W-1:0]   subnet_a;
		logic [ID_W-1:0]   subnet_b;
		logic [1:0]        subnet_count;
		logic [LIFE_W-1:0] lifetime;

		logic [LIFE_W-1:0] life_left[CACHE_ENTRIES];
		logic [ID_W-1:0]   entry_source[CACHE_ENTRIES];
		logic [ID_W-1:0]   entry_subnet[CACHE_ENTRIES];
		logic [SEQ_W-1:0]  entry_seq[CACHE_ENTRIES];

		bit drop_expected[$];
		int errors;

		function new();
			own_source   = '0;
			subnet_a     = '0;
			subnet_b     = '0;
			subnet_count = 2'd1;
			lifetime     = 8'd10;
			errors       = 0;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				life_left[i]    = '0;
				entry_source[i] = '0;
				entry_subnet[i] = '0;
				entry_seq[i]    = '0;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
			case (idx)
				CFG_LOCAL_SOURCE: own_source = data;
				CFG_SUBNET_A: subnet_a = data;
				CFG_SUBNET_B: subnet_b = data;
				CFG_SUBNET_COUNT: subnet_count = data[1:0];
				CFG_LIFETIME: lifetime = data[LIFE_W-1:0];
				default: ;
			endcase
		endfunction

		// Scan in index order: the last free entry is the fallback, a live match ends the scan.
		function bit lookup(logic [ID_W-1:0] sub, logic [ID_W-1:0] src, logic [SEQ_W-1:0] sq);
			int pick;
			bit have;
			bit dup;
			bit local_sub;
			logic [SEQ_W-1:0] diff;
			pick = 0;
			have = 1'b0;
			dup  = 1'b0;
			local_sub = (subnet_count >= 2'd1 && sub == subnet_a) ||
				(subnet_count >= 2'd2 && sub == subnet_b);
			if (src == own_source && local_sub)
				return 1'b1;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (life_left[i] == '0) begin
					pick = i;
					have = 1'b1;
				end else if (entry_source[i] == src && entry_subnet[i] == sub) begin
					diff = sq - entry_seq[i];
					pick = i;
					have = 1'b1;
					dup  = (diff == '0) || diff[SEQ_W-1];
					break;
				end
			end
			if (!have)
				return 1'b1;
			// The chosen entry is refreshed even when the frame turns out to be a duplicate.
			entry_subnet[pick] = sub;
			entry_source[pick] = src;
			entry_seq[pick]    = sq;
			life_left[pick]    = lifetime;
			return dup;
		endfunction

		function void note_request(bit tick, logic [ID_W-1:0] sub, logic [ID_W-1:0] src,
			logic [SEQ_W-1:0] sq);
			if (tick) begin
				for (int i = 0; i < CACHE_ENTRIES; i++)
					if (life_left[i] != '0)
						life_left[i]--;
				drop_expected.push_back(1'b0);
			end else begin
				drop_expected.push_back(lookup(sub, src, sq));
			end
		endfunction

		function void check_result(bit drop);
			bit want;
			if (drop_expected.size() == 0) begin
				$error("unexpected result: drop %0d with no request outstanding", drop);
				errors++;
			end else begin
				want = drop_expected.pop_front();
				if (want != drop) begin
					$error("drop mismatch: expected %0d, actual %0d", want, drop);
					errors++;
				end
			end
		endfunction

		function int pending();
			return drop_expected.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 req_type = 1'b0;
	logic [ID_W-1:0]      subnet_id = '0;
	logic [ID_W-1:0]      source_id = '0;
	logic [SEQ_W-1:0]     seq_num = '0;
	logic                 done;
	logic                 drop;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ID_W-1:0]      cfg_data = '0;

	dup_filter_scoreboard sb = new();

	logic [ID_W-1:0]  pair_source[PAIRS];
	logic [ID_W-1:0]  pair_subnet[PAIRS];
	logic [SEQ_W-1:0] pair_seq[PAIRS];
	bit no_gaps = 1'b0;

	multicast_duplicate_filter #(.CACHE_ENTRIES(CACHE_ENTRIES)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.subnet_id(subnet_id),
		.source_id(source_id),
		.seq_num(seq_num),
		.done(done),
		.drop(drop),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Values are read at the edge before any of the edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_request(req_type, subnet_id, source_id, seq_num);
			if (done)
				sb.check_result(drop);
		end
	end

	// Start stays high into the next request when no gap is drawn.
	task automatic send(bit tick, logic [ID_W-1:0] sub, logic [ID_W-1:0] src,
		logic [SEQ_W-1:0] sq);
		int gap;
		req_type  <= tick;
		subnet_id <= sub;
		source_id <= src;
		seq_num   <= sq;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (CACHE_ENTRIES + 4) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [ID_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(logic [ID_W-1:0] src, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
		logic [1:0] count, logic [LIFE_W-1:0] life);
		cfg_valid <= 1'b1;
		put_reg(CFG_LOCAL_SOURCE, src);
		put_reg(CFG_SUBNET_A, a);
		put_reg(CFG_SUBNET_B, b);
		put_reg(CFG_SUBNET_COUNT, {14'd0, count});
		put_reg(CFG_LIFETIME, {8'd0, life});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] any_id();
		return ID_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic random_request();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			send(1'b1, any_id(), any_id(), SEQ_W'($urandom));
		end else if (r < 25) begin
			send(1'b0, any_id(), any_id(), SEQ_W'($urandom));
		end else if (r < 32) begin
			send(1'b0, $urandom_range(0, 1) ? sb.subnet_a : sb.subnet_b, sb.own_source,
				SEQ_W'($urandom));
		end else begin
			// Mostly small forward steps, now and then a repeat or a jump backwards.
			k = $urandom_range(0, PAIRS - 1);
			pair_seq[k] += ($urandom_range(0, 3) != 0) ? SEQ_W'($urandom_range(1, 3)) :
				SEQ_W'($urandom);
			send(1'b0, pair_subnet[k], pair_source[k], pair_seq[k]);
		end
	endtask

	initial begin
		int counts[PHASES] = '{0, 1, 2, 3, 2, 1};
		int lives[PHASES]  = '{1, 255, 0, 6, 17, 40};
		logic [ID_W-1:0] own;
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'h1234, 16'hAAAA, 16'h5555, 2'd2, 8'd2);
		send(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
		send(1'b0, 16'hAAAA, 16'h1234, 8'h00);
		send(1'b0, 16'h5555, 16'h1234, 8'h7F);
		send(1'b0, 16'h0001, 16'h1234, 8'h10);
		send(1'b0, 16'h0001, 16'h1234, 8'h10);
		send(1'b0, 16'h0001, 16'h1234, 8'h90);
		send(1'b0, 16'h0001, 16'h1234, 8'h0F);
		send(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
		send(1'b0, 16'h0000, 16'h0000, 8'h00);
		// Thirteen new sources fill the cache; the fourteenth finds no room.
		for (int i = 0; i < 14; i++)
			send(1'b0, 16'h7000, 16'h0100 + ID_W'(i), SEQ_W'(i));
		send(1'b1, 16'h0000, 16'h0000, 8'h00);
		send(1'b1, 16'h0000, 16'h0000, 8'h00);
		send(1'b0, 16'h0001, 16'h1234, 8'h0E);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			own = (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0000 : any_id();
			a = (p == 1) ? 16'hFFFF : any_id();
			b = (p == 1) ? 16'h0000 : any_id();
			configure(own, a, b, 2'(counts[p]), 8'(lives[p]));
			for (int k = 0; k < PAIRS; k++) begin
				pair_source[k] = ($urandom_range(0, 3) == 0) ? own : any_id();
				case ($urandom_range(0, 3))
					0: pair_subnet[k] = a;
					1: pair_subnet[k] = b;
					default: pair_subnet[k] = any_id();
				endcase
				pair_seq[k] = SEQ_W'($urandom);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 39) == 0)
					no_gaps = !no_gaps;
				random_request();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mdf_pkg.sv
hw/rtl/mdf_cell.sv
hw/rtl/multicast_duplicate_filter.sv
hw/rtl/mdf_checker.sv
verif/multicast_duplicate_filter_test.sv
